// File: rtl/assert_macros.svh
// Assertion macros used by the table controller; expect clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every clock edge outside reset.
`define CHK_PROP(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// A condition in one cycle implies a consequence in the next.
`define CHK_NEXT(label, cond, nxt, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (nxt)) else $error(msg);

`endif

// File: rtl/chtad_pkg.sv
// Shared constants, types and command struct of the clustered hash table.
`timescale 1ns / 1ps

package chtad_pkg;

  // Table geometry; NUM_CLUSTERS is a power of two, at least 2.
  localparam int NUM_CLUSTERS = 4096;
  localparam int WAYS         = 4;
  localparam int DATE_PERIOD  = 16;

  localparam int ENTRIES    = NUM_CLUSTERS * WAYS;
  localparam int ADDR_W     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CL_W       = $clog2(NUM_CLUSTERS);
  localparam int WAY_W      = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int LOOK_CNT_W = $clog2(WAYS + 1);
  localparam int DATE_W     = $clog2(DATE_PERIOD);
  // age * 256 - depth, signed
  localparam int VAL_W      = DATE_W + 10;

  localparam logic [15:0]        NO_MOVE_RST     = 16'hFFFF;
  localparam logic signed [15:0] EMPTY_SCORE_RST = 16'sh8000;

  localparam int PADDR_W = 3;

  // register index, taken from paddr[2]
  typedef enum logic {
    REG_NO_MOVE     = 1'b0,
    REG_EMPTY_SCORE = 1'b1
  } reg_t;

  typedef enum logic [1:0] {
    REQ_STORE   = 2'd0,
    REQ_PROBE   = 2'd1,
    REQ_ADVANCE = 2'd2,
    REQ_CLEAR   = 2'd3
  } req_t;

  typedef struct packed {
    logic [31:0]        lock;
    logic [15:0]        move;
    logic signed [15:0] score;
    logic [1:0]         flag;
    logic [7:0]         depth;
    logic [DATE_W-1:0]  date;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic [15:0]        no_move_code;
    logic signed [15:0] empty_score;
  } cfg_t;

  typedef struct packed {
    logic              req_load;
    logic              look_rd;
    logic [WAY_W-1:0]  look_way;
    logic              ev_en;
    logic [WAY_W-1:0]  ev_way;
    logic              fin;
    logic              sweep_wr;
    logic              sweep_init;
    logic [ADDR_W-1:0] sweep_addr;
  } cmd_t;

endpackage

// File: rtl/chtad_if.sv
// Request and result channel interfaces of the clustered hash table.
`timescale 1ns / 1ps

interface chtad_req_if;
  logic               valid;
  logic               ready;
  logic [1:0]         req_type;
  logic [11:0]        set_index;
  logic [31:0]        lock_tag;
  logic [15:0]        move_in;
  logic signed [15:0] score_in;
  logic [1:0]         flag_in;
  logic [7:0]         depth_in;

  modport source (
    output valid, req_type, set_index, lock_tag, move_in, score_in, flag_in, depth_in,
    input  ready
  );
  modport sink (
    input  valid, req_type, set_index, lock_tag, move_in, score_in, flag_in, depth_in,
    output ready
  );
endinterface

interface chtad_rsp_if;
  logic               valid;
  logic               ready;
  logic               hit;
  logic [15:0]        found_move;
  logic signed [15:0] found_score;
  logic [1:0]         found_flag;
  logic [7:0]         found_depth;

  modport source (
    output valid, hit, found_move, found_score, found_flag, found_depth,
    input  ready
  );
  modport sink (
    input  valid, hit, found_move, found_score, found_flag, found_depth,
    output ready
  );
endinterface

// File: rtl/clustered_hash_table_age_depth_core.sv
// Top level of the clustered hash table with depth/age replacement.
//
// Requests arrive on in_req (valid/ready transfer): store, probe, advance date,
// clear table. Every request gives exactly one result transfer on out_rsp.
// The set index and lock come pre-hashed; a cluster holds WAYS entries.
// Store and probe read one way of the cluster per cycle from a single table
// RAM, overlapped with evaluation of the previous way; the result is posted
// and in_req is ready again in the same cycle, so no new store or probe is
// taken before the last one has posted its result.
// Advance posts its result from the finish state without a table read.
// Clear writes one entry per cycle over the whole table, then posts a result.
// After reset a like pass (filling the reset values) runs over the whole
// table with in_req not ready; APB writes are taken throughout.
// A result sits in the output register; the next request is taken and
// worked on while it waits, and finishes once out_rsp frees the register.
// The APB port (pready always high) holds no_move_code at 0x0 and
// empty_score at 0x4; write only while no request is pending.
`timescale 1ns / 1ps

module clustered_hash_table_age_depth_core (
  input  logic                          clk,
  input  logic                          rst_n,
  chtad_req_if.sink                     in_req,
  chtad_rsp_if.source                   out_rsp,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [chtad_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  chtad_pkg::cfg_t cfg;
  chtad_pkg::cmd_t cmd;

  chtad_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  chtad_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_req.valid),
    .in_req_type (in_req.req_type),
    .in_ready    (in_req.ready),
    .out_valid   (out_rsp.valid),
    .out_ready   (out_rsp.ready),
    .cmd         (cmd)
  );

  chtad_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .cfg         (cfg),
    .req_type    (in_req.req_type),
    .set_index   (in_req.set_index),
    .lock_tag    (in_req.lock_tag),
    .move_in     (in_req.move_in),
    .score_in    (in_req.score_in),
    .flag_in     (in_req.flag_in),
    .depth_in    (in_req.depth_in),
    .hit         (out_rsp.hit),
    .found_move  (out_rsp.found_move),
    .found_score (out_rsp.found_score),
    .found_flag  (out_rsp.found_flag),
    .found_depth (out_rsp.found_depth)
  );

endmodule

// File: rtl/chtad_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module chtad_ram #(
  parameter  int WIDTH  = 8,
  parameter  int DEPTH  = 16,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/chtad_cfg.sv
// APB-style configuration registers: no-move code and empty score.
`timescale 1ns / 1ps

module chtad_cfg (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [chtad_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  output chtad_pkg::cfg_t              cfg
);

  logic [15:0]        no_move_r;
  logic signed [15:0] empty_score_r;
  chtad_pkg::reg_t    reg_idx;
  logic               wr_fire;

  // registers sit at byte offsets 0 and 4; low address bits are ignored
  assign reg_idx = chtad_pkg::reg_t'(paddr[2]);
  assign wr_fire = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      no_move_r     <= chtad_pkg::NO_MOVE_RST;
      empty_score_r <= chtad_pkg::EMPTY_SCORE_RST;
    end else if (wr_fire) begin
      unique case (reg_idx)
        chtad_pkg::REG_NO_MOVE:     no_move_r     <= pwdata[15:0];
        chtad_pkg::REG_EMPTY_SCORE: empty_score_r <= signed'(pwdata[15:0]);
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      chtad_pkg::REG_NO_MOVE:     prdata = {16'b0, no_move_r};
      chtad_pkg::REG_EMPTY_SCORE: prdata = {16'b0, empty_score_r};
    endcase
  end

  assign cfg.no_move_code = no_move_r;
  assign cfg.empty_score  = empty_score_r;

endmodule

// File: rtl/chtad_ctrl.sv
// Controller: sequences way lookups, table sweeps and result transfers.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module chtad_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic [1:0]      in_req_type,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  output chtad_pkg::cmd_t cmd
);

  localparam int CNT_W  = chtad_pkg::LOOK_CNT_W;
  localparam int WAY_W  = chtad_pkg::WAY_W;
  localparam int ADDR_W = chtad_pkg::ADDR_W;

  typedef enum logic [1:0] {ST_SWEEP, ST_IDLE, ST_LOOK, ST_FIN} state_t;

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  lk_cnt_r, lk_cnt_nxt;
  logic [ADDR_W-1:0] sw_cnt_r, sw_cnt_nxt;
  logic              sw_init_r, sw_init_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              slot_free;
  logic [CNT_W-1:0]  ev_cnt;

  assign slot_free = !out_valid_r || out_ready;
  assign ev_cnt    = lk_cnt_r - CNT_W'(1);

  always_comb begin
    state_nxt   = state_r;
    lk_cnt_nxt  = lk_cnt_r;
    sw_cnt_nxt  = sw_cnt_r;
    sw_init_nxt = sw_init_r;
    in_ready    = 1'b0;

    cmd            = '0;
    cmd.look_way   = lk_cnt_r[WAY_W-1:0];
    cmd.ev_way     = ev_cnt[WAY_W-1:0];
    cmd.sweep_addr = sw_cnt_r;
    cmd.sweep_init = sw_init_r;

    unique case (state_r)
      ST_SWEEP: begin
        cmd.sweep_wr = 1'b1;
        if (sw_cnt_r == ADDR_W'(chtad_pkg::ENTRIES - 1)) begin
          sw_cnt_nxt  = '0;
          sw_init_nxt = 1'b0;
          // the pass after reset has no result; a clear request does
          state_nxt   = sw_init_r ? ST_IDLE : ST_FIN;
        end else begin
          sw_cnt_nxt = sw_cnt_r + ADDR_W'(1);
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.req_load = 1'b1;
          unique case (chtad_pkg::req_t'(in_req_type)) inside
            chtad_pkg::REQ_STORE, chtad_pkg::REQ_PROBE: begin
              lk_cnt_nxt = '0;
              state_nxt  = ST_LOOK;
            end
            chtad_pkg::REQ_ADVANCE: state_nxt = ST_FIN;
            chtad_pkg::REQ_CLEAR: begin
              sw_cnt_nxt = '0;
              state_nxt  = ST_SWEEP;
            end
          endcase
        end
      end
      ST_LOOK: begin
        // read of way n overlaps the evaluation of way n-1
        cmd.look_rd = (lk_cnt_r < CNT_W'(chtad_pkg::WAYS));
        cmd.ev_en   = (lk_cnt_r != '0);
        if (lk_cnt_r == CNT_W'(chtad_pkg::WAYS)) begin
          state_nxt = ST_FIN;
        end else begin
          lk_cnt_nxt = lk_cnt_r + CNT_W'(1);
        end
      end
      ST_FIN: begin
        if (slot_free) begin
          cmd.fin   = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
    endcase

    if (cmd.fin) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_SWEEP;
      lk_cnt_r    <= '0;
      sw_cnt_r    <= '0;
      sw_init_r   <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      lk_cnt_r    <= lk_cnt_nxt;
      sw_cnt_r    <= sw_cnt_nxt;
      sw_init_r   <= sw_init_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  `CHK_NEXT(a_accept_blocks, in_valid && in_ready, !in_ready, "request taken while busy")
  `CHK_NEXT(a_result_posted, cmd.fin, out_valid && in_ready, "result not posted after finish")
  `CHK_PROP(a_look_bound, (state_r == ST_LOOK) |-> (lk_cnt_r <= CNT_W'(chtad_pkg::WAYS)), "way counter overrun")

endmodule

// File: rtl/chtad_dp.sv
// Datapath: request capture, way evaluation, entry update, table RAM, result regs.
`timescale 1ns / 1ps

module chtad_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  chtad_pkg::cmd_t     cmd,
  input  chtad_pkg::cfg_t     cfg,
  input  logic [1:0]          req_type,
  input  logic [11:0]         set_index,
  input  logic [31:0]         lock_tag,
  input  logic [15:0]         move_in,
  input  logic signed [15:0]  score_in,
  input  logic [1:0]          flag_in,
  input  logic [7:0]          depth_in,
  output logic                hit,
  output logic [15:0]         found_move,
  output logic signed [15:0]  found_score,
  output logic [1:0]          found_flag,
  output logic [7:0]          found_depth
);

  localparam int ADDR_W = chtad_pkg::ADDR_W;
  localparam int WAY_W  = chtad_pkg::WAY_W;
  localparam int CL_W   = chtad_pkg::CL_W;
  localparam int DATE_W = chtad_pkg::DATE_W;
  localparam int VAL_W  = chtad_pkg::VAL_W;
  localparam logic signed [VAL_W-1:0] BEST_INIT = VAL_W'(-256);

  // captured request
  chtad_pkg::req_t    req_r;
  logic [CL_W-1:0]    cl_r;
  logic [31:0]        lock_r;
  logic [15:0]        mv_r;
  logic signed [15:0] sc_r;
  logic [1:0]         fl_r;
  logic [7:0]         dp_r;

  // lookup results
  logic                    found_r;
  logic [WAY_W-1:0]        match_way_r;
  logic [WAY_W-1:0]        pick_r;
  logic signed [VAL_W-1:0] best_r;
  chtad_pkg::entry_t       match_ent_r;

  logic [DATE_W-1:0] date_r;

  logic                    hit_r;
  logic [15:0]             move_r;
  logic signed [15:0]      score_r;
  logic [1:0]              flag_r;
  logic [7:0]              depth_r;

  logic [31:0]             idx_ext;
  logic [ADDR_W-1:0]       base;
  logic [ADDR_W-1:0]       rd_addr;
  logic [ADDR_W-1:0]       wr_addr;
  logic [ADDR_W-1:0]       st_addr;
  logic [chtad_pkg::ENTRY_W-1:0] rd_data;
  logic [chtad_pkg::ENTRY_W-1:0] wr_data;
  logic                    wr_en;
  chtad_pkg::entry_t       rd_e;
  chtad_pkg::entry_t       st_e;
  chtad_pkg::entry_t       fill_e;
  logic [DATE_W:0]         age_wrap;
  logic [DATE_W-1:0]       age;
  logic signed [VAL_W-1:0] val;
  logic                    is_probe;
  logic                    is_store;

  assign idx_ext  = 32'(set_index);
  assign base     = ADDR_W'(cl_r) * ADDR_W'(chtad_pkg::WAYS);
  assign rd_addr  = base + ADDR_W'(cmd.look_way);
  assign rd_e     = chtad_pkg::entry_t'(rd_data);
  assign is_probe = (req_r == chtad_pkg::REQ_PROBE);
  assign is_store = (req_r == chtad_pkg::REQ_STORE);

  // age = (current date - entry date) mod the date period
  assign age_wrap = (DATE_W + 1)'({1'b0, date_r} + (DATE_W + 1)'(chtad_pkg::DATE_PERIOD)
                                  - {1'b0, rd_e.date});
  assign age      = (date_r >= rd_e.date) ? (date_r - rd_e.date) : age_wrap[DATE_W-1:0];
  assign val      = signed'(VAL_W'({age, 8'b0})) - signed'(VAL_W'(rd_e.depth));

  always_ff @(posedge clk) begin
    if (cmd.req_load) begin
      req_r  <= chtad_pkg::req_t'(req_type);
      cl_r   <= idx_ext[CL_W-1:0];
      lock_r <= lock_tag;
      mv_r   <= move_in;
      sc_r   <= score_in;
      fl_r   <= flag_in;
      dp_r   <= depth_in;
    end
  end

  // first matching way wins; replacement keeps the first way of the highest value
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= 1'b0;
    end else if (cmd.req_load) begin
      found_r <= 1'b0;
    end else if (cmd.ev_en && !found_r && rd_e.lock == lock_r) begin
      found_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.req_load) begin
      best_r <= BEST_INIT;
      pick_r <= '0;
    end else if (cmd.ev_en && !found_r) begin
      if (rd_e.lock == lock_r) begin
        match_way_r <= cmd.ev_way;
        match_ent_r <= rd_e;
      end else if (val > best_r) begin
        best_r <= val;
        pick_r <= cmd.ev_way;
      end
    end
  end

  always_comb begin
    st_e      = match_ent_r;
    st_e.date = date_r;
    if (match_ent_r.depth <= dp_r) begin
      if (mv_r != cfg.no_move_code) begin
        st_e.move = mv_r;
      end
      st_e.score = sc_r;
      st_e.flag  = fl_r;
      st_e.depth = dp_r;
    end
    if (!found_r) begin
      st_e.lock  = lock_r;
      st_e.move  = mv_r;
      st_e.score = sc_r;
      st_e.flag  = fl_r;
      st_e.depth = dp_r;
      st_e.date  = date_r;
    end
  end

  assign st_addr = base + ADDR_W'(found_r ? match_way_r : pick_r);

  always_comb begin
    fill_e       = '0;
    fill_e.move  = cmd.sweep_init ? chtad_pkg::NO_MOVE_RST : cfg.no_move_code;
    fill_e.score = cmd.sweep_init ? chtad_pkg::EMPTY_SCORE_RST : cfg.empty_score;
  end

  assign wr_en   = cmd.sweep_wr || (cmd.fin && is_store);
  assign wr_addr = cmd.sweep_wr ? cmd.sweep_addr : st_addr;
  assign wr_data = cmd.sweep_wr ? fill_e : st_e;

  chtad_ram #(
    .WIDTH (chtad_pkg::ENTRY_W),
    .DEPTH (chtad_pkg::ENTRIES)
  ) u_table (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .re    (cmd.look_rd),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      date_r <= '0;
    end else if (cmd.fin) begin
      case (req_r)
        chtad_pkg::REQ_ADVANCE:
          date_r <= (date_r == DATE_W'(chtad_pkg::DATE_PERIOD - 1)) ? '0 : date_r + DATE_W'(1);
        chtad_pkg::REQ_CLEAR: date_r <= '0;
        default:              date_r <= date_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fin) begin
      hit_r   <= is_probe && found_r;
      move_r  <= !is_probe ? 16'd0 : (found_r ? match_ent_r.move : cfg.no_move_code);
      score_r <= (is_probe && found_r) ? match_ent_r.score : 16'sd0;
      flag_r  <= (is_probe && found_r) ? match_ent_r.flag : 2'd0;
      depth_r <= (is_probe && found_r) ? match_ent_r.depth : 8'd0;
    end
  end

  assign hit         = hit_r;
  assign found_move  = move_r;
  assign found_score = score_r;
  assign found_flag  = flag_r;
  assign found_depth = depth_r;

endmodule
